// ===== hdl/bqdq_pkg.sv =====
// Shared types and codes for the byte-quota descriptor queue.
// No dependencies; every other file of the block refers to this package by scoped names.
package bqdq_pkg;

  localparam int DEPTH_DEFAULT = 1024;

  localparam int SIZE_W   = 16;
  localparam int HANDLE_W = 32;
  localparam int TAG_W    = 32;
  localparam int CONN_W   = 16;
  localparam int SEQ_W    = 32;
  localparam int BYTES_W  = 32;
  localparam int HELD_W   = 10;

  typedef logic [1:0] cmd_code_t;
  localparam cmd_code_t CMD_PUSH  = 2'd0;
  localparam cmd_code_t CMD_POP   = 2'd1;
  localparam cmd_code_t CMD_QUERY = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_PUSHED    = 3'd0;
  localparam status_t ST_OVERSIZED = 3'd1;
  localparam status_t ST_QUOTA     = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_POPPED    = 3'd4;
  localparam status_t ST_EMPTY     = 3'd5;
  localparam status_t ST_STATUS    = 3'd6;

  // one stored descriptor, 128 bits
  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [CONN_W-1:0]   conn;
    logic [TAG_W-1:0]    tag;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch request beat
    logic exec;    // run the latched command, load the result register
  } ctrl_cmd_t;

endpackage

// ===== hdl/bqdq_if.sv =====
// Channel interfaces of the byte-quota descriptor queue: request, response, configuration.
// Depends on bqdq_pkg for field widths.
interface bqdq_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      command;
  logic [bqdq_pkg::SIZE_W-1:0]     msg_size;
  logic [bqdq_pkg::HANDLE_W-1:0]   payload_handle;
  logic [bqdq_pkg::TAG_W-1:0]      source_tag;
  logic [bqdq_pkg::CONN_W-1:0]     connection_id;

  modport source (output valid, command, msg_size, payload_handle, source_tag,
                  connection_id, input ready);
  modport sink   (input valid, command, msg_size, payload_handle, source_tag,
                  connection_id, output ready);
endinterface

interface bqdq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      status;
  logic [bqdq_pkg::SEQ_W-1:0]      sequence_number;
  logic [bqdq_pkg::SIZE_W-1:0]     out_msg_size;
  logic [bqdq_pkg::HANDLE_W-1:0]   out_payload_handle;
  logic [bqdq_pkg::TAG_W-1:0]      out_source_tag;
  logic [bqdq_pkg::CONN_W-1:0]     out_connection_id;
  logic [bqdq_pkg::HELD_W-1:0]     entries_held;
  logic [bqdq_pkg::BYTES_W-1:0]    bytes_in_use;
  logic [bqdq_pkg::BYTES_W-1:0]    discard_total;

  modport source (output valid, status, sequence_number, out_msg_size, out_payload_handle,
                  out_source_tag, out_connection_id, entries_held, bytes_in_use,
                  discard_total, input ready);
  modport sink   (input valid, status, sequence_number, out_msg_size, out_payload_handle,
                  out_source_tag, out_connection_id, entries_held, bytes_in_use,
                  discard_total, output ready);
endinterface

interface bqdq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bqdq_pkg::BYTES_W-1:0]    quota_limit;

  modport source (output valid, quota_limit, input ready);
  modport sink   (input valid, quota_limit, output ready);
endinterface

// ===== hdl/byte_quota_descriptor_queue.sv =====
// Byte-quota descriptor queue, top level: joins controller and datapath to the three channels.
// Depends on bqdq_pkg, bqdq_if, bqdq_ctrl and bqdq_datapath.
//
// A ring of DEPTH descriptors (DEPTH-1 usable) with byte-quota admission. Each request beat
// (push, pop, query; code 3 acts as query) gives exactly one response beat. A request is taken
// in the IDLE state and executed in the EXEC state once the result register is free; the next
// request is taken while the previous response still waits. The pace is set by the
// controller's take/execute sequence around the registered read of the descriptor memory.
// The memory has no clearing pass; only written entries are ever popped. The quota
// register is written whenever the configuration channel's valid is high and should be
// changed only while no request is in flight.
module byte_quota_descriptor_queue #(
  parameter int DEPTH = bqdq_pkg::DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  bqdq_req_if.sink   req,
  bqdq_rsp_if.source rsp,
  bqdq_cfg_if.sink   cfg
);

  bqdq_pkg::ctrl_cmd_t cmd;

  assign cfg.ready = 1'b1;

  bqdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  bqdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .cfg_valid          (cfg.valid),
    .cfg_quota_limit    (cfg.quota_limit),
    .command            (req.command),
    .msg_size           (req.msg_size),
    .payload_handle     (req.payload_handle),
    .source_tag         (req.source_tag),
    .connection_id      (req.connection_id),
    .status             (rsp.status),
    .sequence_number    (rsp.sequence_number),
    .out_msg_size       (rsp.out_msg_size),
    .out_payload_handle (rsp.out_payload_handle),
    .out_source_tag     (rsp.out_source_tag),
    .out_connection_id  (rsp.out_connection_id),
    .entries_held       (rsp.entries_held),
    .bytes_in_use       (rsp.bytes_in_use),
    .discard_total      (rsp.discard_total)
  );

endmodule

// ===== hdl/bqdq_ctrl.sv =====
// Sequencing controller: accepts one request beat, executes it, holds the response beat.
// Depends on bqdq_pkg for the command struct.
module bqdq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output bqdq_pkg::ctrl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;

  assign req_ready  = (state == S_IDLE);
  assign cmd.accept = req_valid && req_ready;
  // result register may be refilled in the cycle its old beat leaves
  assign cmd.exec   = (state == S_EXEC) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.exec) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_exec_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (!rsp_valid || rsp_ready))
    else $error("result loaded over an untaken beat");

  a_accept_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == S_EXEC) && !req_ready)
    else $error("accepted beat did not enter execution");

  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.exec))
    else $error("response appeared without an executed request");

endmodule

// ===== hdl/bqdq_datapath.sv =====
// Datapath: descriptor ring memory, pointers, byte tally, sequence and drop counters, result register.
// Depends on bqdq_pkg; driven by bqdq_ctrl through ctrl_cmd_t.
module bqdq_datapath #(
  parameter int DEPTH = bqdq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bqdq_pkg::ctrl_cmd_t                 cmd,
  input  logic                                cfg_valid,
  input  logic [bqdq_pkg::BYTES_W-1:0]        cfg_quota_limit,
  input  logic [1:0]                          command,
  input  logic [bqdq_pkg::SIZE_W-1:0]         msg_size,
  input  logic [bqdq_pkg::HANDLE_W-1:0]       payload_handle,
  input  logic [bqdq_pkg::TAG_W-1:0]          source_tag,
  input  logic [bqdq_pkg::CONN_W-1:0]         connection_id,
  output logic [2:0]                          status,
  output logic [bqdq_pkg::SEQ_W-1:0]          sequence_number,
  output logic [bqdq_pkg::SIZE_W-1:0]         out_msg_size,
  output logic [bqdq_pkg::HANDLE_W-1:0]       out_payload_handle,
  output logic [bqdq_pkg::TAG_W-1:0]          out_source_tag,
  output logic [bqdq_pkg::CONN_W-1:0]         out_connection_id,
  output logic [bqdq_pkg::HELD_W-1:0]         entries_held,
  output logic [bqdq_pkg::BYTES_W-1:0]        bytes_in_use,
  output logic [bqdq_pkg::BYTES_W-1:0]        discard_total
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  // latched request
  logic [1:0]                      cmd_q;
  bqdq_pkg::entry_t                req_q;

  // queue state
  logic [AW-1:0]                   wr_idx, wr_idx_next;
  logic [AW-1:0]                   rd_idx, rd_idx_next;
  logic [AW-1:0]                   occ, occ_next;
  logic [bqdq_pkg::BYTES_W-1:0]    tally, tally_next;
  logic [bqdq_pkg::SEQ_W-1:0]      next_seq, next_seq_next;
  logic [bqdq_pkg::BYTES_W-1:0]    drops, drops_next;
  logic [bqdq_pkg::BYTES_W-1:0]    quota_limit;

  bqdq_pkg::entry_t                mem [DEPTH];
  bqdq_pkg::entry_t                rd_data;
  bqdq_pkg::entry_t                wr_data;
  logic                            push_ok;

  logic [bqdq_pkg::SEQ_W-1:0]      seq_inc;
  logic [bqdq_pkg::BYTES_W:0]      sum;
  logic [bqdq_pkg::BYTES_W-1:0]    size_w;
  logic [bqdq_pkg::BYTES_W-1:0]    pop_size_w;
  logic                            quota_on;

  logic [2:0]                      status_next;
  logic [bqdq_pkg::SEQ_W-1:0]      seq_out;
  bqdq_pkg::entry_t                pop_out;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q         <= command;
      req_q.size    <= msg_size;
      req_q.handle  <= payload_handle;
      req_q.tag     <= source_tag;
      req_q.conn    <= connection_id;
      req_q.seq     <= '0;
    end
  end

  assign seq_inc    = next_seq + bqdq_pkg::SEQ_W'(1);
  assign size_w     = bqdq_pkg::BYTES_W'(req_q.size);
  assign pop_size_w = bqdq_pkg::BYTES_W'(rd_data.size);
  assign sum        = {1'b0, tally} + {1'b0, size_w};
  assign quota_on   = (quota_limit != '0);

  always_comb begin
    wr_idx_next   = wr_idx;
    rd_idx_next   = rd_idx;
    occ_next      = occ;
    tally_next    = tally;
    next_seq_next = next_seq;
    drops_next    = drops;
    push_ok       = 1'b0;
    status_next   = bqdq_pkg::ST_STATUS;
    seq_out       = '0;
    pop_out       = '0;
    wr_data       = req_q;
    wr_data.seq   = seq_inc;
    case (cmd_q)
      bqdq_pkg::CMD_PUSH: begin
        next_seq_next = seq_inc;
        seq_out       = seq_inc;
        if (quota_on && (size_w > quota_limit)) begin
          status_next = bqdq_pkg::ST_OVERSIZED;
        end else if (quota_on && (sum > {1'b0, quota_limit})) begin
          status_next = bqdq_pkg::ST_QUOTA;
        end else if (occ == LAST) begin
          status_next = bqdq_pkg::ST_FULL;
        end else begin
          status_next = bqdq_pkg::ST_PUSHED;
          push_ok     = 1'b1;
          wr_idx_next = (wr_idx == LAST) ? '0 : wr_idx + AW'(1);
          occ_next    = occ + AW'(1);
          // saturate the tally on overflow (only reachable with no quota)
          tally_next  = sum[bqdq_pkg::BYTES_W] ? '1 : sum[bqdq_pkg::BYTES_W-1:0];
        end
        if (!push_ok) drops_next = drops + bqdq_pkg::BYTES_W'(1);
      end
      bqdq_pkg::CMD_POP: begin
        if (occ == '0) begin
          status_next = bqdq_pkg::ST_EMPTY;
        end else begin
          status_next = bqdq_pkg::ST_POPPED;
          pop_out     = rd_data;
          seq_out     = rd_data.seq;
          rd_idx_next = (rd_idx == LAST) ? '0 : rd_idx + AW'(1);
          occ_next    = occ - AW'(1);
          tally_next  = (pop_size_w <= tally) ? tally - pop_size_w : '0;
        end
      end
      default: status_next = bqdq_pkg::ST_STATUS;
    endcase
  end

  // ring memory; head entry is prefetched every cycle, and the controller's IDLE state always
  // lies between the last pointer or entry update and the execution of a pop
  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) mem[wr_idx] <= wr_data;
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx      <= '0;
      rd_idx      <= '0;
      occ         <= '0;
      tally       <= '0;
      next_seq    <= '0;
      drops       <= '0;
      quota_limit <= '0;
    end else begin
      if (cfg_valid) quota_limit <= cfg_quota_limit;
      if (cmd.exec) begin
        wr_idx   <= wr_idx_next;
        rd_idx   <= rd_idx_next;
        occ      <= occ_next;
        tally    <= tally_next;
        next_seq <= next_seq_next;
        drops    <= drops_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status             <= status_next;
      sequence_number    <= seq_out;
      out_msg_size       <= pop_out.size;
      out_payload_handle <= pop_out.handle;
      out_source_tag     <= pop_out.tag;
      out_connection_id  <= pop_out.conn;
      entries_held       <= bqdq_pkg::HELD_W'(occ_next);
      bytes_in_use       <= tally_next;
      discard_total      <= drops_next;
    end
  end

  a_drop_step: assert property (@(posedge clk) disable iff (rst)
    (drops == $past(drops)) || (drops == $past(drops) + bqdq_pkg::BYTES_W'(1)))
    else $error("drop counter moved by more than one");

  a_pop_releases: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (cmd_q == bqdq_pkg::CMD_POP) && (occ != '0))
      |=> (tally <= $past(tally)) && (occ == $past(occ) - AW'(1)))
    else $error("pop did not release its entry");

endmodule
